// ----- rtl/core/spd_pkg.sv -----
// Shared types and constants for the servo packet deframer.
package spd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int VALUE_W = 28;
  localparam int OUT_W   = 72;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_HEAD  = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_LAST  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/spd_front.sv -----
// Front end: accepts received bytes, tracks packet position, tags each kept byte.
module spd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  input  spd_pkg::q_stat_t   q_stat,
  output logic               push,
  output spd_pkg::item_t     push_item
);

  logic [2:0] count;
  logic [2:0] count_next;
  logic [2:0] len;
  logic [2:0] len_next;
  logic       accept;

  assign s_axis_tready = !q_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    count_next     = count;
    len_next       = len;
    push           = 1'b0;
    push_item.kind = spd_pkg::KIND_DATA;
    push_item.data = s_axis_tdata;
    if (accept) begin
      if (!s_axis_tdata[7]) begin
        push           = 1'b1;
        push_item.kind = spd_pkg::KIND_START;
        count_next     = 3'd1;
        len_next       = 3'd0;
      end else if (count != 3'd0) begin
        push       = 1'b1;
        count_next = count + 3'd1;
        if (count == 3'd1) begin
          push_item.kind = spd_pkg::KIND_HEAD;
          len_next       = 3'd4 + {1'b0, s_axis_tdata[6:5]};
        end else if (count + 3'd1 == len) begin
          push_item.kind = spd_pkg::KIND_LAST;
          count_next     = 3'd0;
          len_next       = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
      len   <= 3'd0;
    end else begin
      count <= count_next;
      len   <= len_next;
    end
  end

endmodule

// ----- rtl/core/spd_queue.sv -----
// Small FIFO of tagged bytes between the front end and the back end.
module spd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  spd_pkg::item_t     push_item,
  input  logic               pop,
  output spd_pkg::item_t     pop_item,
  output spd_pkg::q_stat_t   q_stat
);

  spd_pkg::item_t                  slots [spd_pkg::QDEPTH];
  logic [spd_pkg::QAW-1:0]         wr_ptr;
  logic [spd_pkg::QAW-1:0]         rd_ptr;
  logic [spd_pkg::QCW-1:0]         fill;

  assign pop_item     = slots[rd_ptr];
  assign q_stat.empty = (fill == '0);
  assign q_stat.full  = (fill == spd_pkg::QCW'(spd_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/spd_back.sv -----
// Back end: accumulates header, checksum and data groups; holds the result item.
module spd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  spd_pkg::item_t              pop_item,
  input  spd_pkg::q_stat_t            q_stat,
  output logic                        pop,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [6:0] node_id, [11:7] func_code, [12] checksum_ok,
  // [40:13] signed_value, [68:41] unsigned_value, [71:69] data_groups
  output logic [spd_pkg::OUT_W-1:0]   m_axis_tdata
);

  logic [6:0]                  node;
  logic [4:0]                  func;
  logic [7:0]                  sum;
  logic [2:0]                  groups;
  logic [spd_pkg::VALUE_W-1:0] sval;
  logic [spd_pkg::VALUE_W-1:0] uval;

  logic [6:0]                  res_node;
  logic [4:0]                  res_func;
  logic                        res_ok;
  logic [spd_pkg::VALUE_W-1:0] res_sval;
  logic [spd_pkg::VALUE_W-1:0] res_uval;
  logic [2:0]                  res_groups;

  logic [7:0] d;
  logic       is_last;

  assign d       = pop_item.data;
  assign is_last = (pop_item.kind == spd_pkg::KIND_LAST);
  assign pop     = !q_stat.empty && (!is_last || !m_axis_tvalid || m_axis_tready);

  assign m_axis_tdata = {res_groups, res_uval, res_sval, res_ok, res_func, res_node};

  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (pop_item.kind)
        spd_pkg::KIND_START: begin
          node <= d[6:0];
          sum  <= d;
        end
        spd_pkg::KIND_HEAD: begin
          func   <= d[4:0];
          sum    <= sum + d;
          groups <= 3'd0;
        end
        spd_pkg::KIND_DATA: begin
          sum    <= sum + d;
          groups <= groups + 3'd1;
          if (groups == 3'd0) begin
            sval <= {{(spd_pkg::VALUE_W-7){d[6]}}, d[6:0]};
            uval <= {{(spd_pkg::VALUE_W-7){1'b0}}, d[6:0]};
          end else begin
            sval <= {sval[spd_pkg::VALUE_W-8:0], d[6:0]};
            uval <= {uval[spd_pkg::VALUE_W-8:0], d[6:0]};
          end
        end
        spd_pkg::KIND_LAST: begin
          res_node   <= node;
          res_func   <= func;
          res_ok     <= (sum[6:0] == d[6:0]);
          res_sval   <= sval;
          res_uval   <= uval;
          res_groups <= groups;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop && is_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/servo_packet_deframer.sv -----
// Top level of the servo packet deframer.
// Takes one received byte per cycle and returns one result item for each complete
// packet (node id, function code, checksum flag, data value signed and unsigned,
// group count). The front end tags bytes and drops stray continuation bytes; a
// four-entry queue feeds the back end, which keeps a running checksum and shifts in
// one 7-bit group per cycle while it pops data bytes. Sustained rate is one byte per
// cycle, set by the single accumulate step per byte in the back end; a result item is
// registered once its last byte is popped from the queue. Input stalls only when the
// queue fills behind a stalled output.
module servo_packet_deframer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] rx_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [6:0] node_id, [11:7] func_code, [12] checksum_ok,
  // [40:13] signed_value, [68:41] unsigned_value, [71:69] data_groups
  output logic [spd_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic               push;
  logic               pop;
  spd_pkg::item_t     push_item;
  spd_pkg::item_t     pop_item;
  spd_pkg::q_stat_t   q_stat;

  spd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  spd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  spd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_item      (pop_item),
    .q_stat        (q_stat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> q_stat.empty && !m_axis_tvalid)
    else $error("queue or output not cleared by reset");

  a_group_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[71:69] != 3'd0) && (m_axis_tdata[71:69] <= 3'd4))
    else $error("data group count out of range");

  a_full_width: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[71:69] == 3'd4) |->
      m_axis_tdata[40:13] == m_axis_tdata[68:41])
    else $error("four-group values differ");

endmodule

// ----- dv/tb_servo_packet_deframer.sv -----
// Self-checking testbench for servo_packet_deframer: packet decode checked against a byte predictor.
`timescale 1ns / 1ps

module tb_servo_packet_deframer;

  typedef struct packed {
    logic [2:0]  data_groups;
    logic [27:0] unsigned_value;
    logic [27:0] signed_value;
    logic        checksum_ok;
    logic [4:0]  func_code;
    logic [6:0]  node_id;
  } frame_t;

  typedef struct {
    logic [7:0] b;
    bit         drain;
  } rx_item_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = 8'h00;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [spd_pkg::OUT_W-1:0] m_axis_tdata;

  rx_item_t   rx_q[$];
  frame_t     frame_q[$];
  int         total_bytes = 0;
  int         bytes_taken = 0;
  int         errs = 0;
  int         pkt_cnt = 0;
  int         pkt_len = 0;
  logic [7:0] pkt_buf[7];
  frame_t     got;
  frame_t     want;

  servo_packet_deframer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  function automatic int run_phase();
    if (bytes_taken * 3 < total_bytes) return 0;
    if (bytes_taken * 3 < total_bytes * 2) return 1;
    return 2;
  endfunction

  function automatic int send_idle_pct();
    case (run_phase())
      0: return 22;
      1: return 83;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (run_phase())
      0: return 83;
      1: return 22;
      default: return 0;
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b, input bit drain);
    rx_item_t it;
    it.b = b;
    it.drain = drain;
    rx_q.push_back(it);
  endtask

  task automatic add_packet(input logic [6:0] node, input logic [4:0] fc,
                            input logic [1:0] lc, input logic [3:0][6:0] g,
                            input bit good, input int keep, input bit drain);
    logic [7:0] pk[7];
    logic [7:0] sum;
    int         len;
    int         n;
    len = 4 + lc;
    pk[0] = {1'b0, node};
    pk[1] = {1'b1, lc, fc};
    for (int i = 0; i < len - 3; i++) pk[2 + i] = {1'b1, g[i]};
    sum = 8'h00;
    for (int i = 0; i < len - 1; i++) sum = sum + pk[i];
    if (good) pk[len - 1] = {1'b1, sum[6:0]};
    else pk[len - 1] = {1'b1, sum[6:0] + 7'($urandom_range(1, 127))};
    n = (keep > 0) ? keep : len;
    for (int i = 0; i < n; i++) put_byte(pk[i], drain && (i == 0));
  endtask

  // track packet framing and queue the decoded frame on completion
  task automatic absorb_byte(input logic [7:0] b);
    logic [7:0]  sum;
    logic [31:0] sval;
    logic [27:0] uval;
    frame_t      f;
    if (!b[7]) begin
      pkt_cnt = 0;
      pkt_len = 0;
    end
    if (b[7] && pkt_cnt == 0) return;
    pkt_buf[pkt_cnt] = b;
    pkt_cnt++;
    if (pkt_cnt == 2) pkt_len = 4 + b[6:5];
    if (pkt_cnt != pkt_len) return;
    sum = 8'h00;
    for (int i = 0; i < pkt_len - 1; i++) sum = sum + pkt_buf[i];
    uval = {21'h0, pkt_buf[2][6:0]};
    sval = {{25{pkt_buf[2][6]}}, pkt_buf[2][6:0]};
    for (int i = 3; i < pkt_len - 1; i++) begin
      uval = {uval[20:0], pkt_buf[i][6:0]};
      sval = {sval[24:0], pkt_buf[i][6:0]};
    end
    f.node_id        = pkt_buf[0][6:0];
    f.func_code      = pkt_buf[1][4:0];
    f.checksum_ok    = (sum[6:0] == pkt_buf[pkt_len - 1][6:0]);
    f.signed_value   = sval[27:0];
    f.unsigned_value = uval;
    f.data_groups    = 3'(pkt_len - 3);
    frame_q.push_back(f);
    pkt_cnt = 0;
    pkt_len = 0;
  endtask

  initial begin
    int         r;
    int         next_drain;
    bit         drain;
    logic [1:0] lc;
    put_byte(8'hFF, 1'b0);
    add_packet(7'h00, 5'h00, 2'd0, {4{7'h00}}, 1'b1, 0, 1'b0);
    add_packet(7'h7F, 5'h1F, 2'd3, {4{7'h7F}}, 1'b1, 0, 1'b0);
    add_packet(7'h55, 5'h0A, 2'd1, {7'h00, 7'h00, 7'h00, 7'h40}, 1'b0, 0, 1'b0);
    add_packet(7'h12, 5'h03, 2'd2, {4{7'h11}}, 1'b1, 3, 1'b0);
    add_packet(7'h7F, 5'h05, 2'd2, {7'h00, 7'h7E, 7'h01, 7'h3F}, 1'b1, 0, 1'b0);
    put_byte(8'h80, 1'b0);
    next_drain = rx_q.size();
    while (rx_q.size() < 1550) begin
      drain = 1'b0;
      if (rx_q.size() >= next_drain) begin
        drain = 1'b1;
        next_drain += 400;
      end
      r = $urandom_range(99);
      lc = 2'($urandom_range(3));
      if (r < 78) begin
        add_packet(7'($urandom), 5'($urandom), lc, 28'($urandom),
                   $urandom_range(99) < 85, 0, drain);
      end else if (r < 90) begin
        add_packet(7'($urandom), 5'($urandom), lc, 28'($urandom),
                   1'b1, $urandom_range(1, 3 + lc), drain);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          put_byte(8'($urandom), drain);
          drain = 1'b0;
        end
      end
    end
    total_bytes = rx_q.size();
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (rx_q.size() != 0 &&
          (!rx_q[0].drain || (!s_axis_tvalid && frame_q.size() == 0)) &&
          $urandom_range(99) >= send_idle_pct()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_q[0].b;
        void'(rx_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_byte(s_axis_tdata);
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (frame_q.size() == 0) begin
          $error("unexpected result item %h", got);
          errs++;
        end else begin
          want = frame_q.pop_front();
          if (got.node_id !== want.node_id) begin
            $error("node_id: expected %0h, got %0h", want.node_id, got.node_id);
            errs++;
          end
          if (got.func_code !== want.func_code) begin
            $error("func_code: expected %0h, got %0h",
                   want.func_code, got.func_code);
            errs++;
          end
          if (got.checksum_ok !== want.checksum_ok) begin
            $error("checksum_ok: expected %0h, got %0h", want.checksum_ok, got.checksum_ok);
            errs++;
          end
          if (got.signed_value !== want.signed_value) begin
            $error("signed_value: expected %0h, got %0h",
                   want.signed_value, got.signed_value);
            errs++;
          end
          if (got.unsigned_value !== want.unsigned_value) begin
            $error("unsigned_value: expected %0h, got %0h",
                   want.unsigned_value, got.unsigned_value);
            errs++;
          end
          if (got.data_groups !== want.data_groups) begin
            $error("data_groups: expected %0h, got %0h", want.data_groups, got.data_groups);
            errs++;
          end
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    while (rx_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errs == 0) begin
      $display("** servo_packet_deframer: PASSED **");
    end else begin
      $display("** servo_packet_deframer: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** servo_packet_deframer: FAILED **");
    $finish;
  end

endmodule
